[design/em3_pkg.sv]
package em3_pkg;

  localparam int PIX_W = 8;
  localparam int CFG_W = 11;
  localparam int GRAD_W = 10;   // |column sum difference| <= 765
  localparam int SQ_W = 21;     // gx^2 + gy^2 <= 1170450
  localparam int ROOT_W = 11;
  localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;

  localparam logic [0:0] REG_WIDTH = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  // Work item handed from the window front end to the root back end.
  typedef struct packed {
    logic [GRAD_W-1:0] gx;
    logic [GRAD_W-1:0] gy;
    logic              valid;
    logic              fend;
  } em3_job_t;

endpackage

[design/em3_front.sv]
module em3_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [em3_pkg::CFG_W-1:0] eff_w,
  input  logic [em3_pkg::CFG_W-1:0] eff_h,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [em3_pkg::PIX_W-1:0] pixel,
  output logic                   job_valid,
  input  logic                   job_stall,
  output em3_pkg::em3_job_t      job
);
  import em3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_CALC, S_OUT} state_t;
  state_t state;

  logic [PIX_W-1:0] mem_a [MAX_WIDTH];
  logic [PIX_W-1:0] mem_b [MAX_WIDTH];
  logic [PIX_W-1:0] rd_mid, rd_top, px;
  logic [PIX_W-1:0] win [6];
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic in_range, win_ok, row_end, frame_last;
  logic [GRAD_W-1:0] sl, sr, st, sb;

  assign in_stall = (state != S_IDLE);
  assign in_range = (col < CW'(MAX_WIDTH));
  assign win_ok = (col >= CW'(2)) && (row >= RW'(2));
  assign row_end = (CFG_W'(col) + CFG_W'(1) >= eff_w);
  assign frame_last = (CFG_W'(row) + CFG_W'(1) >= eff_h);

  // Line store read in S_IDLE accept cycle, write-back in S_CALC.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      rd_mid <= mem_a[col[AW-1:0]];
      rd_top <= mem_b[col[AW-1:0]];
    end
    if (state == S_CALC && in_range) begin
      mem_a[col[AW-1:0]] <= px;
      mem_b[col[AW-1:0]] <= rd_mid;
    end
  end

  logic [PIX_W-1:0] top_v, mid_v;
  assign top_v = in_range ? rd_top : '0;
  assign mid_v = in_range ? rd_mid : '0;

  always_comb begin
    sl = GRAD_W'(win[0]) + GRAD_W'(win[1]) + GRAD_W'(win[2]);
    sr = GRAD_W'(top_v) + GRAD_W'(mid_v) + GRAD_W'(px);
    st = GRAD_W'(win[0]) + GRAD_W'(win[3]) + GRAD_W'(top_v);
    sb = GRAD_W'(win[2]) + GRAD_W'(win[5]) + GRAD_W'(px);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      col <= '0;
      row <= '0;
      job_valid <= 1'b0;
      for (int i = 0; i < 6; i++) win[i] <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          px <= pixel;
          state <= S_READ;
        end
        S_READ: state <= S_CALC;
        S_CALC: begin
          job.gx <= (sl >= sr) ? sl - sr : sr - sl;
          job.gy <= (st >= sb) ? st - sb : sb - st;
          job.valid <= win_ok;
          job.fend <= row_end && frame_last;
          job_valid <= 1'b1;
          win[0] <= win[3]; win[1] <= win[4]; win[2] <= win[5];
          win[3] <= top_v;  win[4] <= mid_v;  win[5] <= px;
          if (row_end) begin
            col <= '0;
            row <= frame_last ? '0 : row + RW'(1);
          end else begin
            col <= col + CW'(1);
          end
          state <= S_OUT;
        end
        S_OUT: if (!job_stall) begin
          job_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[design/em3_queue.sv]
module em3_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_stall,
  input  em3_pkg::em3_job_t wr_data,
  output logic              rd_valid,
  input  logic              rd_stall,
  output em3_pkg::em3_job_t rd_data
);
  import em3_pkg::*;

  em3_job_t slot [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic do_wr, do_rd;

  assign wr_stall = (cnt == 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_data = slot[rp];
  assign do_wr = wr_valid && !wr_stall;
  assign do_rd = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (do_wr) slot[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (do_wr) wp <= ~wp;
      if (do_rd) rp <= ~rp;
      cnt <= cnt + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

[design/em3_back.sv]
module em3_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      job_valid,
  output logic                      job_stall,
  input  em3_pkg::em3_job_t         job,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [em3_pkg::PIX_W-1:0] edge_value,
  output logic                      window_valid,
  output logic                      frame_end
);
  import em3_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SQX, S_ROOT, S_OUT} state_t;
  state_t state;

  logic [SQ_W-1:0] sqx;
  logic [ROOT_W-1:0] root;
  logic [3:0] step;
  logic [GRAD_W-1:0] gy;
  logic valid_q, fend_q;

  assign job_stall = (state != S_IDLE);

  // src is the radicand padded to an even bit count so pairs align at bit 0
  logic [SQ_W+1:0] acc;
  logic [SQ_W:0] src;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (job_valid) begin
          sqx <= SQ_W'(job.gx * job.gx);
          gy <= job.gy;
          valid_q <= job.valid;
          fend_q <= job.fend;
          state <= S_SQX;
        end
        S_SQX: begin
          src <= {1'b0, sqx + SQ_W'(gy * gy)};
          acc <= '0;
          root <= '0;
          step <= 4'd10;
          state <= S_ROOT;
        end
        // Restoring square root, one result bit per cycle.
        S_ROOT: begin
          logic [SQ_W+1:0] a2;
          logic [SQ_W+1:0] t;
          a2 = {acc[SQ_W-1:0], src[SQ_W -: 2]};
          t = (SQ_W+2)'({root, 2'b01});
          if (a2 >= t) begin
            acc <= a2 - t;
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            acc <= a2;
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          src <= {src[SQ_W-2:0], 2'b00};
          if (step == 4'd0) state <= S_OUT;
          step <= step - 4'd1;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            window_valid <= valid_q;
            frame_end <= fend_q;
            if (!valid_q || root > ROOT_W'(FULL_SCALE)) edge_value <= '0;
            else edge_value <= FULL_SCALE - root[PIX_W-1:0];
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[design/edge_magnitude_3x3.sv]
// edge_magnitude_3x3: streaming 3x3 inverted Prewitt edge magnitude. Pixels
// arrive in raster order (8 bits each); every accepted pixel yields exactly
// one result: edge_value = 255 - floor(sqrt(gx^2+gy^2)) (0 if that root
// exceeds 255, or when no full window ends here), window_valid set when
// column >= 2 and row >= 2, frame_end on the last pixel of a frame. Width and
// height are clamped to [3, MAX] before use. The front end takes a new pixel
// only after the line-store read, window sum and handoff of the last; the
// back end's bit-serial square root, one item at a time, sets the sustained
// rate. A two-entry queue decouples the two. No clearing pass after reset.
module edge_magnitude_3x3 #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  edge_value,
  output logic        window_valid,
  output logic        frame_end
);
  import em3_pkg::*;

  logic [CFG_W-1:0] image_width, image_height, eff_w, eff_h;

  // config transfers always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= CFG_W'(384);
      image_height <= CFG_W'(240);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp to [3, MAX]
  assign eff_w = (image_width < CFG_W'(3)) ? CFG_W'(3) :
                 (32'(image_width) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : image_width;
  assign eff_h = (image_height < CFG_W'(3)) ? CFG_W'(3) :
                 (32'(image_height) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : image_height;

  logic f_valid, f_stall, q_valid, q_stall;
  em3_job_t f_job, q_job;

  em3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst, .eff_w, .eff_h, .in_valid, .in_stall, .pixel,
    .job_valid(f_valid), .job_stall(f_stall), .job(f_job)
  );

  em3_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_job),
    .rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_job)
  );

  em3_back u_back (
    .clk, .rst, .job_valid(q_valid), .job_stall(q_stall), .job(q_job),
    .out_valid, .out_stall, .edge_value, .window_valid, .frame_end
  );

`ifndef NO_ASSERTIONS
  // no edge value without a window
  a_nowin_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !window_valid) |-> (edge_value == '0))
    else $error("edge value without window");
  // a result under stall holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(edge_value)))
    else $error("stalled result changed");
`endif

endmodule
